// ===== sv/rtcst_pkg.sv =====
// rtcst_pkg: shared types, constants and the month table for the rtc stamp timer resume block
// no dependencies; imported by the controller, the datapath and the top level

package rtcst_pkg;

  // default tick rate of the timer counter
  localparam int unsigned TICKS_PER_SECOND_DEF = 4194304;
  localparam int unsigned TICKS_PER_SECOND_MAX = 100000000;

  localparam int unsigned SECS_PER_DAY  = 86400;
  localparam int unsigned SECS_PER_HOUR = 3600;
  localparam int unsigned DAYS_PER_YEAR = 365;

  // counter clear threshold and longest accepted off-time, in seconds
  localparam logic [63:0] CLEAR_SECS   = 64'(512) * 64'(SECS_PER_DAY);
  localparam logic [63:0] MAX_OFF_SECS = 64'(DAYS_PER_YEAR) * 64'(SECS_PER_DAY);

  localparam int unsigned DAYS_W = 16;  // day count since 2000, year byte up to 165
  localparam int unsigned HMS_W  = 20;  // seconds within a day, unchecked bytes included
  localparam int unsigned SECS_W = 33;  // seconds since 2000

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DEC  = 7'b0000010,
    S_DAYS = 7'b0000100,
    S_SECS = 7'b0001000,
    S_MUL  = 7'b0010000,
    S_CMP  = 7'b0100000,
    S_FIN  = 7'b1000000
  } rtcst_state_e;

  // step strobes from the controller to the datapath
  typedef struct packed {
    logic cap;
    logic dec;
    logic days;
    logic secs;
    logic mul;
    logic cmp;
    logic fin;
  } rtcst_cmd_t;

  typedef enum logic {
    KIND_STORE = 1'b0,
    KIND_LOAD  = 1'b1
  } rtcst_kind_e;

  // day of year at which each month starts, non-leap
  function automatic logic [8:0] month_start(input logic [3:0] idx);
    logic [8:0] r;
    unique case (idx)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd59;
      4'd3:    r = 9'd90;
      4'd4:    r = 9'd120;
      4'd5:    r = 9'd151;
      4'd6:    r = 9'd181;
      4'd7:    r = 9'd212;
      4'd8:    r = 9'd243;
      4'd9:    r = 9'd273;
      4'd10:   r = 9'd304;
      4'd11:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/rtcst_in_if.sv =====
// rtcst_in_if: input channel of the rtc stamp timer resume block, valid/ready plus one word
// no dependencies

interface rtcst_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [63:0] counter;
  logic        timer_cart;
  logic        rtc_ok;
  logic [31:0] time_word;
  logic [31:0] date_word;

  modport source (
    output valid, kind, counter, timer_cart, rtc_ok, time_word, date_word,
    input  ready
  );
  modport sink (
    input  valid, kind, counter, timer_cart, rtc_ok, time_word, date_word,
    output ready
  );
endinterface

// ===== sv/rtcst_out_if.sv =====
// rtcst_out_if: result channel of the rtc stamp timer resume block, valid/ready plus one word
// no dependencies

interface rtcst_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] counter_out;
  logic [63:0] wall_stamp;
  logic        stamp_valid;

  modport source (
    output valid, counter_out, wall_stamp, stamp_valid,
    input  ready
  );
  modport sink (
    input  valid, counter_out, wall_stamp, stamp_valid,
    output ready
  );
endinterface

// ===== sv/rtc_stamp_timer_resume.sv =====
// rtc_stamp_timer_resume: timer counter snapshot and resume against rtc time, top level
// depends on rtcst_pkg, rtcst_in_if, rtcst_out_if, rtcst_ctrl and rtcst_dp
//
// usage:
//   in_i carries one word per save or load event: kind (0 store, 1 load), the
//   counter, timer_cart, rtc_ok and the bcd time and date words of the rtc.
//   out_o returns one word per input word: the resulting counter (the input
//   counter on store), the rtc time in ticks since 2000 and its valid flag.
//   a word is taken on a rising clk_i edge with valid and ready both high.
// sequencing:
//   once a word is taken, the decode, day count, seconds multiply, tick
//   multiply, compare and finish steps run one per cycle on one shared
//   sequencer, the finish step waiting while the output register is full;
//   so one word is in flight at a time and the next is taken after its finish.
// reset:
//   rst_ni clears the sequencer, the output valid flag, the saved counter and
//   the saved stamp (zero means no stamp).
// stall:
//   a result waits in the output register while out_o.ready is low; the next
//   word is still taken and worked on, and holds in its finish step until the
//   output register is free.

module rtc_stamp_timer_resume
  import rtcst_pkg::*;
#(
  parameter int unsigned TICKS_PER_SECOND = TICKS_PER_SECOND_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  rtcst_in_if.sink      in_i,
  rtcst_out_if.source   out_o
);

  rtcst_cmd_t cmd;

  rtcst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  rtcst_dp #(
    .TICKS_PER_SECOND (TICKS_PER_SECOND)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .kind_i        (in_i.kind),
    .counter_i     (in_i.counter),
    .timer_cart_i  (in_i.timer_cart),
    .rtc_ok_i      (in_i.rtc_ok),
    .time_word_i   (in_i.time_word),
    .date_word_i   (in_i.date_word),
    .counter_out_o (out_o.counter_out),
    .wall_stamp_o  (out_o.wall_stamp),
    .stamp_valid_o (out_o.stamp_valid)
  );

endmodule

// ===== sv/rtcst_ctrl.sv =====
// rtcst_ctrl: step sequencer and output valid flag of the rtc stamp timer resume block
// depends on rtcst_pkg

module rtcst_ctrl
  import rtcst_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output rtcst_cmd_t cmd_o
);

  rtcst_state_e state_q, state_d;
  logic         out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          state_d   = S_DEC;
        end
      end
      S_DEC: begin
        cmd_o.dec = 1'b1;
        state_d   = S_DAYS;
      end
      S_DAYS: begin
        cmd_o.days = 1'b1;
        state_d    = S_SECS;
      end
      S_SECS: begin
        cmd_o.secs = 1'b1;
        state_d    = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_CMP;
      end
      S_CMP: begin
        cmd_o.cmp = 1'b1;
        state_d   = S_FIN;
      end
      S_FIN: begin
        // finish only when the output register is free or being emptied
        if (!out_valid_q || out_ready_i) begin
          cmd_o.fin = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = (out_valid_q && !out_ready_i) || cmd_o.fin;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== sv/rtcst_dp.sv =====
// rtcst_dp: bcd decode, tick scaling, resume arithmetic, saved state and output register
// depends on rtcst_pkg; driven step by step by rtcst_ctrl

module rtcst_dp
  import rtcst_pkg::*;
#(
  parameter int unsigned TICKS_PER_SECOND = TICKS_PER_SECOND_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  rtcst_cmd_t  cmd_i,
  input  logic        kind_i,
  input  logic [63:0] counter_i,
  input  logic        timer_cart_i,
  input  logic        rtc_ok_i,
  input  logic [31:0] time_word_i,
  input  logic [31:0] date_word_i,
  output logic [63:0] counter_out_o,
  output logic [63:0] wall_stamp_o,
  output logic        stamp_valid_o
);

  localparam int unsigned TPS_W  = $clog2(TICKS_PER_SECOND + 1);
  localparam int unsigned PROD_W = SECS_W + TPS_W;
  localparam logic [TPS_W-1:0] TPS = TPS_W'(TICKS_PER_SECOND);
  localparam logic [63:0] CLEAR_LIMIT = CLEAR_SECS * 64'(TICKS_PER_SECOND);
  localparam logic [63:0] MAX_OFF     = MAX_OFF_SECS * 64'(TICKS_PER_SECOND);

  function automatic logic [7:0] bcd_byte(input logic [7:0] b);
    return 8'({4'd0, b[7:4]} * 8'd10) + {4'd0, b[3:0]};
  endfunction

  // captured word
  logic        kind_q, timer_q, rtc_q;
  logic [63:0] cnt_q;
  logic [31:0] time_q, date_q;
  // decoded fields
  logic [7:0]  sec_q, min_q, hr_q, day_q, mon_q, yr_q;
  logic        valid_q;
  logic [DAYS_W-1:0] days_q;
  logic [HMS_W-1:0]  hms_q;
  logic [SECS_W-1:0] secs_q;
  logic [63:0] stamp_q;
  logic [63:0] cnt_clr_q, off_q;
  logic        fwd_q;
  // persistent state
  logic [63:0] saved_q, wall_q;
  // output register
  logic [63:0] out_cnt_q, out_stamp_q;
  logic        out_valid_stamp_q;

  logic [7:0]        sec_d, min_d, hr_d, day_d, mon_d, yr_d;
  logic              valid_d;
  logic [DAYS_W-1:0] days_d;
  logic [HMS_W-1:0]  hms_d;
  logic [SECS_W-1:0] secs_d;
  logic [PROD_W-1:0] prod;
  logic [64:0]       diff;
  logic              is_load, resume;
  logic [63:0]       cnt_res;

  always_comb begin
    sec_d = bcd_byte(time_q[7:0]);
    min_d = bcd_byte(time_q[15:8]);
    hr_d  = bcd_byte(time_q[23:16]);
    day_d = bcd_byte(date_q[7:0]);
    mon_d = bcd_byte(date_q[15:8]);
    yr_d  = bcd_byte(date_q[23:16]);
    valid_d = rtc_q && (sec_d <= 8'd59) && (min_d <= 8'd59) && (hr_d <= 8'd23) &&
              (day_d >= 8'd1) && (day_d <= 8'd31) && (mon_d >= 8'd1) && (mon_d <= 8'd12);
  end

  always_comb begin
    days_d = DAYS_W'(DAYS_W'(yr_q) * DAYS_W'(DAYS_PER_YEAR))
           + DAYS_W'((9'(yr_q) + 9'd3) >> 2)
           + DAYS_W'(month_start(4'(mon_q - 8'd1)))
           + DAYS_W'((yr_q[1:0] == 2'd0) && (mon_q > 8'd2))
           + DAYS_W'(day_q) - DAYS_W'(1);
    hms_d  = HMS_W'(HMS_W'(hr_q) * HMS_W'(SECS_PER_HOUR))
           + HMS_W'(HMS_W'(min_q) * HMS_W'(60))
           + HMS_W'(sec_q);
    secs_d = SECS_W'(SECS_W'(days_q) * SECS_W'(SECS_PER_DAY)) + SECS_W'(hms_q);
    prod   = PROD_W'(secs_q) * PROD_W'(TPS);
  end

  // borrow of the subtract tells whether the off-time runs forward
  assign diff    = {1'b0, stamp_q} - {1'b0, wall_q};
  assign is_load = (kind_q == KIND_LOAD);
  assign resume  = is_load && timer_q && (wall_q != 64'd0) && valid_q && fwd_q &&
                   (off_q <= MAX_OFF);
  assign cnt_res = resume ? (saved_q + off_q) : cnt_clr_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      kind_q  <= kind_i;
      cnt_q   <= counter_i;
      timer_q <= timer_cart_i;
      rtc_q   <= rtc_ok_i;
      time_q  <= time_word_i;
      date_q  <= date_word_i;
    end
    if (cmd_i.dec) begin
      sec_q   <= sec_d;
      min_q   <= min_d;
      hr_q    <= hr_d;
      day_q   <= day_d;
      mon_q   <= mon_d;
      yr_q    <= yr_d;
      valid_q <= valid_d;
    end
    if (cmd_i.days) begin
      days_q <= days_d;
      hms_q  <= hms_d;
    end
    if (cmd_i.secs) begin
      secs_q <= secs_d;
    end
    if (cmd_i.mul) begin
      stamp_q <= valid_q ? 64'(prod) : 64'd0;
    end
    if (cmd_i.cmp) begin
      cnt_clr_q <= (is_load && timer_q && (cnt_q >= CLEAR_LIMIT)) ? 64'd0 : cnt_q;
      off_q     <= diff[63:0];
      fwd_q     <= !diff[64];
    end
    if (cmd_i.fin) begin
      out_cnt_q         <= is_load ? cnt_res : cnt_q;
      out_stamp_q       <= stamp_q;
      out_valid_stamp_q <= valid_q;
    end
  end

  // snapshot state, written on store only
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      saved_q <= 64'd0;
      wall_q  <= 64'd0;
    end else if (cmd_i.fin && !is_load) begin
      saved_q <= cnt_q;
      wall_q  <= timer_q ? stamp_q : 64'd0;
    end
  end

  assign counter_out_o = out_cnt_q;
  assign wall_stamp_o  = out_stamp_q;
  assign stamp_valid_o = out_valid_stamp_q;

endmodule

// ===== sv/rtcst_checker.sv =====
// rtcst_checker: port-level checks of rtc_stamp_timer_resume, bound to the top level
// depends on rtc_stamp_timer_resume port names only

module rtcst_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [63:0] counter_out_i,
  input logic [63:0] wall_stamp_i,
  input logic        stamp_valid_i
);

  // a stalled result keeps its word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(counter_out_i) &&
      $stable(wall_stamp_i) && $stable(stamp_valid_i))
    else $error("stalled result changed");

  // an invalid rtc time reports a zero stamp
  a_stamp_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !stamp_valid_i |-> wall_stamp_i == 64'd0)
    else $error("non-zero stamp without valid time");

  // one word in flight: busy right after taking a word
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken while busy");

  // a new result only comes out of a word in flight
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i))
    else $error("result without a word in flight");

endmodule

bind rtc_stamp_timer_resume rtcst_checker u_rtcst_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .counter_out_i (out_o.counter_out),
  .wall_stamp_i  (out_o.wall_stamp),
  .stamp_valid_i (out_o.stamp_valid)
);
